@@ design/cmrs_pkg.sv @@
// Shared types, constants and the base complement function for the match run splitter.
package cmrs_pkg;

  localparam int unsigned PosBitsDefault = 32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned BaseW = 8;
  localparam int unsigned FieldW = 32;

  localparam logic KindEq = 1'b0;
  localparam logic KindX = 1'b1;

  localparam logic [FieldW-1:0] LenMax = '1;

  typedef struct packed {
    logic              kind;
    logic [FieldW-1:0] length;
    logic [FieldW-1:0] ref_offset;
    logic [FieldW-1:0] query_offset;
    logic              is_last;
  } run_t;

  function automatic logic [BaseW-1:0] dna_complement(input logic [BaseW-1:0] c);
    logic [BaseW-1:0] r;
    unique case (c)
      8'h41:   r = 8'h54;
      8'h54:   r = 8'h41;
      8'h43:   r = 8'h47;
      8'h47:   r = 8'h43;
      8'h61:   r = 8'h74;
      8'h74:   r = 8'h61;
      8'h63:   r = 8'h67;
      8'h67:   r = 8'h63;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

@@ design/cigar_match_run_splitter_core.sv @@
// Top level of the match run splitter: run tracking and the result queue.
//
// Usage: one aligned column is offered per beat on the input channel
// (in_valid_i / in_stall_o) with its reference base, query base, first and
// last marks and, on the first column, the starting offsets. Each beat
// produces zero, one or two run beats on the output channel (out_valid_o /
// out_stall_i): a run closed by a change of kind, then the final run when
// op_last_i is set. The reversed register is written through cfg_we_i and
// cfg_data_i; the user must write it only while the block is idle, which
// the block itself does not enforce. A column is folded into the run state
// in the cycle it is accepted, and its runs are written into the result
// queue that feeds the output. The block takes one column per cycle; a
// column that closes two runs pushes two queue entries, and the four-entry
// result queue absorbs that, so the input stalls only when fewer than two
// queue entries are free. Reset clears the run state, the queue pointers and
// count and the reversed register. While the receiver stalls, the head run
// holds and the queue fills until the input stalls in turn.
module cigar_match_run_splitter_core #(
  parameter int unsigned PosBits = cmrs_pkg::PosBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [cmrs_pkg::BaseW-1:0]  ref_base_i,
  input  logic [cmrs_pkg::BaseW-1:0]  query_base_i,
  input  logic                        op_first_i,
  input  logic                        op_last_i,
  input  logic [cmrs_pkg::FieldW-1:0] start_ref_offset_i,
  input  logic [cmrs_pkg::FieldW-1:0] start_query_offset_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        run_kind_o,
  output logic [cmrs_pkg::FieldW-1:0] run_length_o,
  output logic [cmrs_pkg::FieldW-1:0] run_ref_offset_o,
  output logic [cmrs_pkg::FieldW-1:0] run_query_offset_o,
  output logic                        run_is_last_o
);
  import cmrs_pkg::*;

  localparam int unsigned OffW = (PosBits < FieldW) ? PosBits : FieldW;
  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] AcceptLimit = CntW'(QueueDepth - 2);

  logic                reversed_q;
  logic                kind_q, kind_d;
  logic [FieldW-1:0]   len_q, len_d;
  logic [OffW-1:0]     ref_off_q, ref_off_d;
  logic [OffW-1:0]     qry_off_q, qry_off_d;

  run_t                queue_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  logic                in_accept;
  logic                out_accept;
  logic [BaseW-1:0]    qbase_eff;
  logic                col_kind;
  logic                push_a, push_b;
  run_t                res_a, res_b;
  logic                mid_kind;
  logic [FieldW-1:0]   mid_len;
  logic [OffW-1:0]     mid_ref, mid_qry;
  logic [PtrW-1:0]     wr_ptr_b;

  assign in_stall_o = (count_q > AcceptLimit);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != '0);
  assign out_accept = out_valid_o && !out_stall_i;

  assign qbase_eff = reversed_q ? dna_complement(query_base_i) : query_base_i;
  assign col_kind  = (ref_base_i == qbase_eff) ? KindEq : KindX;

  always_comb begin
    push_a   = 1'b0;
    res_a    = '0;
    mid_kind = kind_q;
    mid_len  = len_q;
    mid_ref  = ref_off_q;
    mid_qry  = qry_off_q;
    priority if (op_first_i) begin
      mid_kind = col_kind;
      mid_len  = FieldW'(1);
      mid_ref  = start_ref_offset_i[OffW-1:0];
      mid_qry  = start_query_offset_i[OffW-1:0];
    end else if (len_q == '0) begin
      mid_kind = col_kind;
      mid_len  = FieldW'(1);
    end else if (col_kind == kind_q) begin
      if (len_q != LenMax) begin
        mid_len = len_q + FieldW'(1);
      end
    end else begin
      push_a             = 1'b1;
      res_a.kind         = kind_q;
      res_a.length       = len_q;
      res_a.ref_offset   = FieldW'(ref_off_q);
      res_a.query_offset = FieldW'(qry_off_q);
      res_a.is_last      = 1'b0;
      mid_kind           = col_kind;
      mid_len            = FieldW'(1);
      mid_ref            = ref_off_q + len_q[OffW-1:0];
      mid_qry            = reversed_q ? (qry_off_q - len_q[OffW-1:0])
                                      : (qry_off_q + len_q[OffW-1:0]);
    end
  end

  always_comb begin
    push_b             = op_last_i;
    res_b.kind         = mid_kind;
    res_b.length       = mid_len;
    res_b.ref_offset   = FieldW'(mid_ref);
    res_b.query_offset = FieldW'(mid_qry);
    res_b.is_last      = 1'b1;
    kind_d             = mid_kind;
    len_d              = mid_len;
    ref_off_d          = mid_ref;
    qry_off_d          = mid_qry;
    if (op_last_i) begin
      len_d     = '0;
      ref_off_d = mid_ref + mid_len[OffW-1:0];
      qry_off_d = reversed_q ? (mid_qry - mid_len[OffW-1:0])
                             : (mid_qry + mid_len[OffW-1:0]);
    end
  end

  assign wr_ptr_b = push_a ? (wr_ptr_q + PtrW'(1)) : wr_ptr_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (in_accept) begin
      wr_ptr_d = wr_ptr_q + PtrW'(push_a) + PtrW'(push_b);
      count_d  = count_d + CntW'(push_a) + CntW'(push_b);
    end
    if (out_accept) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
      count_d  = count_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reversed_q <= 1'b0;
      kind_q     <= KindEq;
      len_q      <= '0;
      ref_off_q  <= '0;
      qry_off_q  <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        reversed_q <= cfg_data_i;
      end
      if (in_accept) begin
        kind_q    <= kind_d;
        len_q     <= len_d;
        ref_off_q <= ref_off_d;
        qry_off_q <= qry_off_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && push_a) begin
      queue_q[wr_ptr_q] <= res_a;
    end
    if (in_accept && push_b) begin
      queue_q[wr_ptr_b] <= res_b;
    end
  end

  assign run_kind_o         = queue_q[rd_ptr_q].kind;
  assign run_length_o       = queue_q[rd_ptr_q].length;
  assign run_ref_offset_o   = queue_q[rd_ptr_q].ref_offset;
  assign run_query_offset_o = queue_q[rd_ptr_q].query_offset;
  assign run_is_last_o      = queue_q[rd_ptr_q].is_last;

  // The queue never holds more runs than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("result queue overflow");

  // A last column always leaves a run waiting on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && op_last_i |=> out_valid_o)
    else $error("final run missing after last column");

  // A last column closes the open run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && op_last_i |=> len_q == '0)
    else $error("run left open after last column");

  // A first column that is not also last opens a run of one column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && op_first_i && !op_last_i |=> len_q == FieldW'(1))
    else $error("first column did not start a fresh run");

  // Runs held on a stalled output are not dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && !in_accept |=> count_q == $past(count_q))
    else $error("queued run lost under stall");

endmodule
